>>> src/dmwc_pkg.sv
// Shared types and codes for the direct-mapped write-back cache with mapped I/O ports.
// No dependencies; imported by dmwc_lines and the top level.
`default_nettype none
package dmwc_pkg;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_UNINIT = 2'd2,
    ST_EXHAUST = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_IN_PORT  = 2'd0,
    CFG_OUT_PORT = 2'd1,
    CFG_CACHE_EN = 2'd2
  } cfg_reg_t;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_STORE = 1'b1;

  localparam int unsigned CNT_W = 48;

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_DECIDE = 10'b00_0000_0100,
    S_WB_RD  = 10'b00_0000_1000,
    S_WB_WR  = 10'b00_0001_0000,
    S_FL_RD  = 10'b00_0010_0000,
    S_FL_WR  = 10'b00_0100_0000,
    S_FIN    = 10'b00_1000_0000,
    S_RESP   = 10'b01_0000_0000,
    S_SPARE  = 10'b10_0000_0000
  } state_t;

  // line metadata update for the line addressed by meta_idx
  typedef struct packed {
    logic fill;       // write tag, set valid, clear dirty
    logic set_dirty;
    logic clr_dirty;
  } line_ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] hits;
    logic [31:0]      output_word;
    logic             output_valid;
    logic             input_taken;
    logic             was_hit;
    logic [31:0]      read_word;
    status_t          status;
  } result_t;

endpackage
`default_nettype wire

>>> src/dmwc_store.sv
// Main memory: word data array plus per-word written bitmap, one read and one write port.
// Read data registered. No package dependencies.
`default_nettype none
module dmwc_store #(
  parameter int unsigned MEM_WORDS = 65536,
  parameter int unsigned WA = 16
) (
  input  wire logic          clk,
  input  wire logic [WA-1:0] rd_addr,
  output logic [31:0]        rd_data,
  output logic               rd_written,
  input  wire logic [WA-1:0] wr_addr,
  input  wire logic          data_we,
  input  wire logic [31:0]   data_wr,
  input  wire logic          wmap_we,
  input  wire logic          wmap_wr
);

  logic [31:0] data_mem [MEM_WORDS];
  logic        wmap_mem [MEM_WORDS];

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[wr_addr] <= data_wr;
    end
    if (wmap_we) begin
      wmap_mem[wr_addr] <= wmap_wr;
    end
    rd_data    <= data_mem[rd_addr];
    rd_written <= wmap_mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> src/dmwc_lines.sv
// Cache arrays: line word memory, tag memory, valid and dirty flags per line.
// Depends on dmwc_pkg for the metadata control struct.
`default_nettype none
module dmwc_lines #(
  parameter int unsigned NUM_LINES = 64,
  parameter int unsigned LINE_WORDS = 4,
  parameter int unsigned LA = 8,
  parameter int unsigned IW = 6,
  parameter int unsigned TW = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [LA-1:0]      word_rd_addr,
  output logic [31:0]             word_rd_data,
  input  wire logic               word_we,
  input  wire logic [LA-1:0]      word_wr_addr,
  input  wire logic [31:0]        word_wr_data,
  input  wire logic [IW-1:0]      tag_rd_idx,
  output logic [TW-1:0]           tag_rd_data,
  input  wire logic [IW-1:0]      meta_idx,
  input  wire dmwc_pkg::line_ctl_t meta_ctl,
  input  wire logic [TW-1:0]      meta_tag,
  output logic                    meta_valid,
  output logic                    meta_dirty
);
  import dmwc_pkg::*;

  logic [31:0]   word_mem [NUM_LINES*LINE_WORDS];
  logic [TW-1:0] tag_mem  [NUM_LINES];
  logic [NUM_LINES-1:0] valid;
  logic [NUM_LINES-1:0] dirty;

  always_ff @(posedge clk) begin
    if (word_we) begin
      word_mem[word_wr_addr] <= word_wr_data;
    end
    word_rd_data <= word_mem[word_rd_addr];
    if (meta_ctl.fill) begin
      tag_mem[meta_idx] <= meta_tag;
    end
    tag_rd_data <= tag_mem[tag_rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      dirty <= '0;
    end else begin
      if (meta_ctl.fill) begin
        valid[meta_idx] <= 1'b1;
        dirty[meta_idx] <= 1'b0;
      end else if (meta_ctl.set_dirty) begin
        dirty[meta_idx] <= 1'b1;
      end else if (meta_ctl.clr_dirty) begin
        dirty[meta_idx] <= 1'b0;
      end
    end
  end

  assign meta_valid = valid[meta_idx];
  assign meta_dirty = dirty[meta_idx];

endmodule
`default_nettype wire

>>> src/direct_mapped_writeback_cache_mmio.sv
// Word load/store unit with a direct-mapped write-back, write-allocate cache in front of a
// word-addressed main memory, and two byte addresses mapped to an input and an output port.
// After reset the block sweeps main memory and the written bitmap to zero, one word a cycle,
// and takes no item meanwhile. Items are handled one at a time: a load or store that needs
// no cache fill passes memory read, decision and result register; a miss adds a fill that
// reads and writes each line word in turn plus a step to finish the line, and a dirty victim
// is first written back word by word, since every line word moves through the
// registered-read memories.
// The result register lets the next item enter while a result waits on the output.
// Depends on dmwc_pkg, dmwc_store, dmwc_lines.
`default_nettype none
module direct_mapped_writeback_cache_mmio #(
  parameter int unsigned MEM_WORDS = 65536,
  parameter int unsigned NUM_LINES = 64,
  parameter int unsigned LINE_WORDS = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // byte_address, write_word, float_convert, input_word, input_available, zero fill
  input  wire logic [103:0] s_tdata,
  // op
  input  wire logic         s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // read_word, was_hit, input_taken, output_valid, output_word, hits_so_far,
  // misses_so_far, zero fill
  output logic [167:0]      m_tdata,
  // status
  output logic [1:0]        m_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  import dmwc_pkg::*;

  localparam int unsigned LN = LINE_WORDS * NUM_LINES;
  localparam int unsigned WA = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int unsigned LA = (LN > 1) ? $clog2(LN) : 1;
  localparam int unsigned IW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int unsigned OW = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
  localparam int unsigned NTAGS = (MEM_WORDS + LN - 1) / LN;
  localparam int unsigned TW = (NTAGS > 1) ? $clog2(NTAGS) : 1;
  localparam logic [32:0] ADDR_LIM = 33'(MEM_WORDS) << 2;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  function automatic logic [31:0] f2i(input logic [31:0] f);
    logic [7:0]  e;
    logic [7:0]  sh;
    logic [31:0] mm;
    logic [31:0] mag;
    e   = f[30:23];
    sh  = e - 8'd127;
    mm  = {8'd0, 1'b1, f[22:0]};
    mag = (sh >= 8'd23) ? (mm << (sh - 8'd23)) : (mm >> (8'd23 - sh));
    if (e == 8'hFF && f[22:0] != 23'd0) begin
      f2i = 32'd0;
    end else if (e < 8'd127) begin
      f2i = 32'd0;
    end else if (e >= 8'd158) begin
      f2i = f[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      f2i = f[31] ? (32'd0 - mag) : mag;
    end
  endfunction

  // configuration
  logic [31:0] in_port;
  logic [31:0] out_port;
  logic        cache_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_port  <= 32'd0;
      out_port <= 32'd4;
      cache_en <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IN_PORT:  in_port  <= cfg_data;
        CFG_OUT_PORT: out_port <= cfg_data;
        CFG_CACHE_EN: cache_en <= cfg_data[0];
        default: ;
      endcase
    end
  end
  assign cfg_ready = 1'b1;

  // incoming word, split
  logic [31:0] in_addr;
  logic [31:0] in_w32;
  logic [31:0] in_off32;
  logic [31:0] in_idx32;
  logic [31:0] in_slot32;
  assign in_addr   = s_tdata[31:0];
  assign in_w32    = {2'b00, in_addr[31:2]};
  assign in_off32  = in_w32 % LINE_WORDS;
  assign in_idx32  = (in_w32 / LINE_WORDS) % NUM_LINES;
  assign in_slot32 = in_w32 % LN;

  state_t state;
  logic              op_q;
  logic [31:0]       wdata_q;
  logic              fconv_q;
  logic [31:0]       inword_q;
  logic              inavail_q;
  logic              is_in_q;
  logic              is_out_q;
  logic              range_err_q;
  logic [31:0]       w_q;
  logic [OW-1:0]     off_q;
  logic [IW-1:0]     idx_q;
  logic [TW-1:0]     tag_q;
  logic [OW-1:0]     cnt;
  logic [WA-1:0]     clr;
  logic [31:0]       vbase;
  result_t           res;
  result_t           res_out;
  result_t           out_q;
  logic [CNT_W-1:0]  hit_cnt;
  logic [CNT_W-1:0]  miss_cnt;

  // memory ports
  logic [31:0]   st_rd_data;
  logic          st_rd_written;
  logic [WA-1:0] st_rd_addr;
  logic [WA-1:0] st_wr_addr;
  logic          st_data_we;
  logic [31:0]   st_data_wr;
  logic          st_wmap_we;
  logic          st_wmap_wr;
  logic [LA-1:0] ln_rd_addr;
  logic [31:0]   ln_rd_data;
  logic          ln_we;
  logic [LA-1:0] ln_wr_addr;
  logic [31:0]   ln_wr_data;
  logic [TW-1:0] tag_rd;
  line_ctl_t     meta_ctl;
  logic          meta_valid;
  logic          meta_dirty;

  logic [31:0] line_base32;
  logic [31:0] cnt32;
  logic [31:0] wb_addr32;
  logic [31:0] fl_addr32;
  logic [31:0] conv_word;
  logic        line_hit;
  logic        cached;
  logic        last_word;
  logic        go_fill;

  assign line_base32 = 32'(idx_q) * LINE_WORDS;
  assign cnt32       = 32'(cnt);
  assign wb_addr32   = vbase + cnt32;
  assign fl_addr32   = w_q - 32'(off_q) + cnt32;
  assign conv_word   = fconv_q ? f2i(inword_q) : inword_q;
  assign line_hit    = meta_valid && (tag_rd == tag_q);
  assign cached      = cache_en && !is_out_q && !is_in_q;
  assign last_word   = (cnt == OW'(LINE_WORDS - 1));
  // cached access without error that misses the line: a store, or a load of a written word
  assign go_fill     = !range_err_q && cached && !line_hit && (op_q == OP_STORE || st_rd_written);

  assign s_tready = (state == S_IDLE);

  always_comb begin
    res_out        = res;
    res_out.hits   = hit_cnt;
    res_out.misses = miss_cnt;
  end

  always_comb begin
    st_rd_addr = (state == S_IDLE) ? in_w32[WA-1:0] : fl_addr32[WA-1:0];
    ln_rd_addr = (state == S_IDLE) ? in_slot32[LA-1:0] : LA'(line_base32 + cnt32);
    st_wr_addr = w_q[WA-1:0];
    st_data_we = 1'b0;
    st_data_wr = wdata_q;
    st_wmap_we = 1'b0;
    st_wmap_wr = 1'b1;
    ln_we      = 1'b0;
    ln_wr_addr = LA'(line_base32 + 32'(off_q));
    ln_wr_data = wdata_q;
    meta_ctl   = '0;
    unique case (state)
      S_CLEAR: begin
        st_wr_addr = clr;
        st_data_we = 1'b1;
        st_data_wr = 32'd0;
        st_wmap_we = 1'b1;
        st_wmap_wr = 1'b0;
      end
      S_DECIDE: begin
        if (!range_err_q) begin
          if (op_q == OP_LOAD) begin
            if (is_in_q && inavail_q) begin
              st_data_we = 1'b1;
              st_data_wr = conv_word;
              st_wmap_we = 1'b1;
            end
          end else begin
            st_wmap_we = 1'b1;
            st_data_we = !cached;
            if (cached && line_hit) begin
              ln_we = 1'b1;
              meta_ctl.set_dirty = 1'b1;
            end
          end
        end
      end
      S_WB_WR: begin
        st_wr_addr = wb_addr32[WA-1:0];
        st_data_we = (wb_addr32 < MEM_WORDS);
        st_data_wr = ln_rd_data;
        meta_ctl.clr_dirty = last_word;
      end
      S_FL_WR: begin
        ln_we      = 1'b1;
        ln_wr_addr = LA'(line_base32 + cnt32);
        ln_wr_data = (fl_addr32 < MEM_WORDS) ? st_rd_data : 32'd0;
        meta_ctl.fill = last_word;
      end
      S_FIN: begin
        ln_we = (op_q == OP_STORE);
        meta_ctl.set_dirty = (op_q == OP_STORE);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr      <= '0;
      cnt      <= '0;
      hit_cnt  <= '0;
      miss_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_RESP) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == WA'(MEM_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            op_q        <= s_tuser;
            wdata_q     <= s_tdata[63:32];
            fconv_q     <= s_tdata[64];
            inword_q    <= s_tdata[96:65];
            inavail_q   <= s_tdata[97];
            is_in_q     <= (in_addr == in_port);
            is_out_q    <= (in_addr == out_port);
            range_err_q <= ({1'b0, in_addr} >= ADDR_LIM);
            w_q         <= in_w32;
            off_q       <= OW'(in_off32);
            idx_q       <= IW'(in_idx32);
            tag_q       <= TW'(in_w32 / LN);
            res         <= '0;
            state       <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state <= !go_fill ? S_RESP : ((meta_valid && meta_dirty) ? S_WB_RD : S_FL_RD);
          cnt   <= '0;
          vbase <= 32'(tag_rd) * LN + line_base32;
          if (range_err_q) begin
            res.status <= ST_RANGE;
          end else if (op_q == OP_LOAD && !st_rd_written && !is_in_q) begin
            res.status <= ST_UNINIT;
          end else if (op_q == OP_LOAD && is_in_q) begin
            if (!inavail_q) begin
              res.status <= ST_EXHAUST;
            end else begin
              res.read_word    <= conv_word;
              res.input_taken  <= 1'b1;
              res.output_valid <= is_out_q;
              res.output_word  <= is_out_q ? conv_word : 32'd0;
            end
          end else if (!cached) begin
            if (op_q == OP_LOAD) begin
              res.read_word <= st_rd_data;
            end else begin
              res.output_valid <= is_out_q;
              res.output_word  <= is_out_q ? wdata_q : 32'd0;
            end
          end else if (line_hit) begin
            res.was_hit <= 1'b1;
            if (hit_cnt != CNT_MAX) begin
              hit_cnt <= hit_cnt + 1'b1;
            end
            if (op_q == OP_LOAD) begin
              res.read_word <= ln_rd_data;
            end
          end else begin
            if (miss_cnt != CNT_MAX) begin
              miss_cnt <= miss_cnt + 1'b1;
            end
          end
        end
        S_WB_RD: state <= S_WB_WR;
        S_WB_WR: begin
          cnt   <= last_word ? '0 : cnt + 1'b1;
          state <= last_word ? S_FL_RD : S_WB_RD;
        end
        S_FL_RD: state <= S_FL_WR;
        S_FL_WR: begin
          if (cnt == off_q && op_q == OP_LOAD) begin
            res.read_word <= ln_wr_data;
          end
          cnt   <= cnt + 1'b1;
          state <= last_word ? S_FIN : S_FL_RD;
        end
        S_FIN: state <= S_RESP;
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            out_q    <= res_out;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {5'd0, out_q.misses, out_q.hits, out_q.output_word, out_q.output_valid,
                    out_q.input_taken, out_q.was_hit, out_q.read_word};
  assign m_tuser = out_q.status;

  dmwc_store #(
    .MEM_WORDS(MEM_WORDS),
    .WA(WA)
  ) u_store (
    .clk(clk),
    .rd_addr(st_rd_addr),
    .rd_data(st_rd_data),
    .rd_written(st_rd_written),
    .wr_addr(st_wr_addr),
    .data_we(st_data_we),
    .data_wr(st_data_wr),
    .wmap_we(st_wmap_we),
    .wmap_wr(st_wmap_wr)
  );

  dmwc_lines #(
    .NUM_LINES(NUM_LINES),
    .LINE_WORDS(LINE_WORDS),
    .LA(LA),
    .IW(IW),
    .TW(TW)
  ) u_lines (
    .clk(clk),
    .rst(rst),
    .word_rd_addr(ln_rd_addr),
    .word_rd_data(ln_rd_data),
    .word_we(ln_we),
    .word_wr_addr(ln_wr_addr),
    .word_wr_data(ln_wr_data),
    .tag_rd_idx(IW'(in_idx32)),
    .tag_rd_data(tag_rd),
    .meta_idx(idx_q),
    .meta_ctl(meta_ctl),
    .meta_tag(tag_q),
    .meta_valid(meta_valid),
    .meta_dirty(meta_dirty)
  );

  // write-back only ever runs on a valid, dirty victim
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WB_RD) |-> (meta_valid && meta_dirty))
    else $error("write-back of a clean or invalid line");

  // a hit is only reported on an access that completed without error
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[32]) |-> (m_tuser == ST_OK))
    else $error("hit flagged on an errored access");

  // an out-of-range access touches no port
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_RANGE) |-> (!m_tdata[33] && !m_tdata[34]))
    else $error("port activity on an out-of-range access");

endmodule
`default_nettype wire

>>> sim/tb_direct_mapped_writeback_cache_mmio.sv
// Self-checking testbench for direct_mapped_writeback_cache_mmio: a queue-fed stream driver,
// an item-level model of memory, written map, cache lines and counters, and a result checker.
// Depends on dmwc_pkg and the RTL under src/.
`timescale 1ns / 100ps
module tb_direct_mapped_writeback_cache_mmio;
  import dmwc_pkg::*;

  localparam int unsigned MEMW = 65536;
  localparam int unsigned NLINES = 64;
  localparam int unsigned LWORDS = 4;
  localparam logic [47:0] CNT_TOP = 48'hFFFF_FFFF_FFFF;
  localparam int LIMIT_CYCLES = 1500000;

  typedef enum int {K_ITEM, K_CFG, K_DRAIN} job_kind_t;

  typedef struct packed {
    logic        op;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic        fconv;
    logic [31:0] inword;
    logic        inavail;
  } access_t;

  typedef struct {
    job_kind_t   kind;
    access_t     acc;
    cfg_reg_t    reg_sel;
    logic [31:0] reg_val;
  } job_t;

  typedef struct packed {
    logic [31:0] rd;
    status_t     st;
    logic        hit;
    logic        taken;
    logic        ov;
    logic [31:0] ow;
    logic [47:0] hits;
    logic [47:0] misses;
  } outcome_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [103:0]  s_tdata = '0;
  logic          s_tuser = 1'b0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [167:0]  m_tdata;
  logic [1:0]    m_tuser;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [1:0]    cfg_index = '0;
  logic [31:0]   cfg_data = '0;

  direct_mapped_writeback_cache_mmio i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // model state
  logic [31:0] mem_words [MEMW];
  logic        mem_written [MEMW];
  logic [31:0] cline_data [NLINES*LWORDS];
  logic [7:0]  cline_tag [NLINES];
  logic        cline_valid [NLINES];
  logic        cline_dirty [NLINES];
  logic [47:0] hit_cnt, miss_cnt;
  logic [31:0] in_port, out_port;
  logic        cache_on;

  job_t     pending[$];
  outcome_t expected_results[$];
  int       errors = 0;
  int       accepted_items = 0;
  int       results_seen = 0;
  int       cycles = 0;
  logic     s_acc = 1'b0, cfg_acc = 1'b0;
  int       hold_left = 0;
  logic     hold_done = 1'b0;
  logic     calm;

  assign calm = accepted_items >= 700 && accepted_items < 1000;

  function automatic logic [31:0] float_to_int32(logic [31:0] f);
    int          ex;
    logic [31:0] mag;
    ex = int'(f[30:23]) - 127;
    if (f[30:23] == 8'hFF && f[22:0] != 0) return 32'd0;
    if (ex < 0) return 32'd0;
    if (ex >= 31) return f[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    mag = {8'd0, 1'b1, f[22:0]};
    mag = (ex >= 23) ? mag << (ex - 23) : mag >> (23 - ex);
    return f[31] ? -mag : mag;
  endfunction

  function automatic logic [47:0] bump(logic [47:0] c);
    return (c >= CNT_TOP) ? CNT_TOP : c + 48'd1;
  endfunction

  // cached access to word w: returns slot, updates counters, evicts and fills on a miss
  function automatic int line_lookup(logic [31:0] w, output logic hit);
    int          idx, base;
    logic [7:0]  tag;
    idx = w[7:2];
    tag = w[15:8];
    if (cline_valid[idx] && cline_tag[idx] == tag) begin
      hit_cnt = bump(hit_cnt);
      hit = 1'b1;
    end else begin
      miss_cnt = bump(miss_cnt);
      hit = 1'b0;
      if (cline_valid[idx] && cline_dirty[idx]) begin
        base = (int'(cline_tag[idx]) * NLINES + idx) * LWORDS;
        for (int i = 0; i < LWORDS; i++) mem_words[base + i] = cline_data[idx*LWORDS + i];
      end
      cline_dirty[idx] = 1'b0;
      cline_tag[idx] = tag;
      cline_valid[idx] = 1'b1;
      base = (int'(tag) * NLINES + idx) * LWORDS;
      for (int i = 0; i < LWORDS; i++) cline_data[idx*LWORDS + i] = mem_words[base + i];
    end
    return idx * LWORDS + int'(w[1:0]);
  endfunction

  function automatic outcome_t run_access(access_t a);
    outcome_t    r;
    logic [31:0] w;
    logic        is_in, is_out, h;
    int          s;
    r = '0;
    r.st = ST_OK;
    w = a.addr >> 2;
    is_in = (a.addr == in_port);
    is_out = (a.addr == out_port);
    h = 1'b0;
    if (a.addr >= MEMW * 4) begin
      r.st = ST_RANGE;
    end else if (a.op == OP_LOAD) begin
      if (!mem_written[w] && !is_in) begin
        r.st = ST_UNINIT;
      end else if (is_in) begin
        if (!a.inavail) begin
          r.st = ST_EXHAUST;
        end else begin
          r.rd = a.fconv ? float_to_int32(a.inword) : a.inword;
          r.taken = 1'b1;
          mem_written[w] = 1'b1;
          if (is_out) begin
            r.ov = 1'b1;
            r.ow = r.rd;
          end
          mem_words[w] = r.rd;
        end
      end else if (is_out || !cache_on) begin
        r.rd = mem_words[w];
      end else begin
        s = line_lookup(w, h);
        r.rd = cline_data[s];
      end
    end else begin
      mem_written[w] = 1'b1;
      if (is_in || is_out) begin
        if (is_out) begin
          r.ov = 1'b1;
          r.ow = a.wdata;
        end
        mem_words[w] = a.wdata;
      end else if (!cache_on) begin
        mem_words[w] = a.wdata;
      end else begin
        s = line_lookup(w, h);
        cline_data[s] = a.wdata;
        cline_dirty[s / LWORDS] = 1'b1;
      end
    end
    r.hit = h;
    r.hits = hit_cnt;
    r.misses = miss_cnt;
    return r;
  endfunction

  // acceptance, prediction and checking
  always @(posedge clk) begin
    outcome_t e, got;
    access_t  a;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
    s_acc <= s_tvalid && s_tready;
    cfg_acc <= cfg_valid && cfg_ready;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        got.rd = m_tdata[31:0];
        got.hit = m_tdata[32];
        got.taken = m_tdata[33];
        got.ov = m_tdata[34];
        got.ow = m_tdata[66:35];
        got.hits = m_tdata[114:67];
        got.misses = m_tdata[162:115];
        got.st = status_t'(m_tuser);
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (got.rd !== e.rd) begin
            $error("read_word expected %h got %h", e.rd, got.rd); errors++;
          end
          if (got.st !== e.st) begin
            $error("status expected %0d got %0d", e.st, got.st); errors++;
          end
          if (got.hit !== e.hit) begin
            $error("was_hit expected %b got %b", e.hit, got.hit); errors++;
          end
          if (got.taken !== e.taken) begin
            $error("input_taken expected %b got %b", e.taken, got.taken); errors++;
          end
          if (got.ov !== e.ov) begin
            $error("output_valid expected %b got %b", e.ov, got.ov); errors++;
          end
          if (got.ow !== e.ow) begin
            $error("output_word expected %h got %h", e.ow, got.ow); errors++;
          end
          if (got.hits !== e.hits) begin
            $error("hits_so_far expected %0d got %0d", e.hits, got.hits); errors++;
          end
          if (got.misses !== e.misses) begin
            $error("misses_so_far expected %0d got %0d", e.misses, got.misses); errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        a.op = s_tuser;
        a.addr = s_tdata[31:0];
        a.wdata = s_tdata[63:32];
        a.fconv = s_tdata[64];
        a.inword = s_tdata[96:65];
        a.inavail = s_tdata[97];
        expected_results.push_back(run_access(a));
        accepted_items++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_IN_PORT:  in_port = cfg_data;
          CFG_OUT_PORT: out_port = cfg_data;
          CFG_CACHE_EN: cache_on = cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // stream and register driver
  always @(negedge clk) begin
    logic v_n, c_n;
    job_t j;
    v_n = s_tvalid;
    c_n = cfg_valid;
    if (s_acc) v_n = 1'b0;
    if (cfg_acc) c_n = 1'b0;
    if (!rst && !v_n && !c_n && pending.size() > 0) begin
      j = pending[0];
      if (j.kind == K_ITEM) begin
        if (calm || $urandom_range(99) >= 26) begin
          s_tdata <= {6'd0, j.acc.inavail, j.acc.inword, j.acc.fconv, j.acc.wdata, j.acc.addr};
          s_tuser <= j.acc.op;
          v_n = 1'b1;
          void'(pending.pop_front());
        end
      end else if (expected_results.size() == 0 && !s_tvalid) begin
        if (j.kind == K_CFG) begin
          cfg_index <= j.reg_sel;
          cfg_data <= j.reg_val;
          c_n = 1'b1;
        end
        void'(pending.pop_front());
      end
    end
    s_tvalid <= v_n;
    cfg_valid <= c_n;
  end

  // result sink with random back-pressure and one long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (!hold_done && results_seen >= 300) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || $urandom_range(99) >= 26;
    end
  end

  task automatic add_access(logic op, logic [31:0] addr, logic [31:0] wdata,
                            logic fconv, logic [31:0] inword, logic inavail);
    job_t j;
    j.kind = K_ITEM;
    j.acc = '{op, addr, wdata, fconv, inword, inavail};
    j.reg_sel = CFG_IN_PORT;
    j.reg_val = '0;
    pending.push_back(j);
  endtask

  task automatic add_setting(logic [31:0] inp, logic [31:0] outp, logic en);
    job_t j;
    j.kind = K_CFG;
    j.acc = '0;
    j.reg_sel = CFG_IN_PORT;   j.reg_val = inp;  pending.push_back(j);
    j.reg_sel = CFG_OUT_PORT;  j.reg_val = outp; pending.push_back(j);
    j.reg_sel = CFG_CACHE_EN;  j.reg_val = {31'd0, en}; pending.push_back(j);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_float();
    logic [31:0] f;
    f = $urandom;
    case ($urandom_range(5))
      0: f[30:23] = 8'hFF;
      1: f[30:23] = 8'(127 + $urandom_range(34));
      2: f[30:23] = 8'(120 + $urandom_range(10));
      default: ;
    endcase
    return f;
  endfunction

  task automatic add_random(logic [31:0] inp, logic [31:0] outp);
    logic [31:0] addr;
    int          r;
    r = $urandom_range(99);
    if (r < 10) addr = inp;
    else if (r < 18) addr = outp;
    else if (r < 22) addr = 32'h0004_0000 + $urandom_range(32'hFFFB_FFFF);
    else if (r < 26) addr = $urandom_range(32'h0003_FFFF);
    else begin
      // small working set: a few tags over a few lines, so hits, conflicts and evictions
      addr = {14'd0, ($urandom_range(9) == 0) ? 8'hFF : 8'($urandom_range(3)),
              6'($urandom_range(7)), 2'($urandom_range(3)), 2'd0};
      if ($urandom_range(15) == 0) addr[1:0] = 2'($urandom_range(3));
    end
    add_access(1'($urandom_range(1)), addr, pick_word(), 1'($urandom_range(1)),
               $urandom_range(1) ? pick_float() : $urandom, $urandom_range(99) < 85);
  endtask

  initial begin
    job_t j;
    logic [31:0] ins [6];
    logic [31:0] outs [6];
    logic        ens [6];
    for (int i = 0; i < MEMW; i++) begin
      mem_words[i] = '0;
      mem_written[i] = 1'b0;
    end
    for (int i = 0; i < NLINES; i++) begin
      cline_valid[i] = 1'b0;
      cline_dirty[i] = 1'b0;
      cline_tag[i] = '0;
    end
    for (int i = 0; i < NLINES*LWORDS; i++) cline_data[i] = '0;
    hit_cnt = '0;
    miss_cnt = '0;
    in_port = 32'd0;
    out_port = 32'd4;
    cache_on = 1'b1;

    // directed part, reset settings
    add_access(OP_LOAD,  32'h0000_0008, 32'd0, 1'b0, 32'd0, 1'b1);          // never written
    add_access(OP_STORE, 32'h0000_0008, 32'h7FFF_FFFF, 1'b0, 32'd0, 1'b1);
    add_access(OP_LOAD,  32'h0000_0008, 32'd0, 1'b0, 32'd0, 1'b1);          // hit
    add_access(OP_LOAD,  32'h0000_0000, 32'd0, 1'b1, 32'h4000_0000, 1'b0);  // exhausted
    add_access(OP_LOAD,  32'h0000_0000, 32'd0, 1'b1, 32'h7FC0_0000, 1'b1);  // NaN
    add_access(OP_LOAD,  32'h0000_0000, 32'd0, 1'b1, 32'h7F80_0000, 1'b1);  // +inf
    add_access(OP_LOAD,  32'h0000_0000, 32'd0, 1'b1, 32'hFF80_0000, 1'b1);  // -inf
    add_access(OP_LOAD,  32'h0000_0000, 32'd0, 1'b1, 32'h4F00_0000, 1'b1);  // 2^31
    add_access(OP_LOAD,  32'h0000_0000, 32'd0, 1'b1, 32'hCF00_0000, 1'b1);  // -2^31
    add_access(OP_LOAD,  32'h0000_0000, 32'd0, 1'b1, 32'hBFC0_0000, 1'b1);  // -1.5
    add_access(OP_LOAD,  32'h0000_0000, 32'd0, 1'b1, 32'h3F00_0000, 1'b1);  // 0.5
    add_access(OP_LOAD,  32'h0000_0000, 32'd0, 1'b1, 32'h4E6E_6B28, 1'b1);
    add_access(OP_LOAD,  32'h0000_0000, 32'd0, 1'b0, 32'hDEAD_BEEF, 1'b1);  // raw bits
    add_access(OP_STORE, 32'h0000_0004, 32'h8000_0000, 1'b0, 32'd0, 1'b1);  // output port
    add_access(OP_LOAD,  32'h0000_0004, 32'd0, 1'b0, 32'd0, 1'b1);
    add_access(OP_STORE, 32'h0004_0000, 32'h1234_5678, 1'b0, 32'd0, 1'b1);  // out of range
    add_access(OP_LOAD,  32'hFFFF_FFFF, 32'd0, 1'b0, 32'd0, 1'b1);
    add_access(OP_STORE, 32'h0000_0400, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b1);  // evicts dirty
    add_access(OP_LOAD,  32'h0000_0008, 32'd0, 1'b0, 32'd0, 1'b1);          // refill
    add_access(OP_STORE, 32'h0003_FFFC, 32'h0000_0001, 1'b0, 32'd0, 1'b1);  // top word
    add_access(OP_LOAD,  32'h0003_FFFC, 32'd0, 1'b0, 32'd0, 1'b1);
    for (int i = 0; i < 120; i++) add_random(32'd0, 32'd4);
    j.kind = K_DRAIN;
    j.acc = '0;
    j.reg_sel = CFG_IN_PORT;
    j.reg_val = '0;
    pending.push_back(j);
    for (int i = 0; i < 60; i++) add_random(32'd0, 32'd4);

    ins  = '{32'h10, 32'h3FFFC, 32'hFFFF_FFFF, 32'h101, 32'h40, 32'h0};
    outs = '{32'h10, 32'h3FFF8, 32'h0, 32'h202, 32'h44, 32'hFFFF_FFFF};
    ens  = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    for (int p = 0; p < 6; p++) begin
      add_setting(ins[p], outs[p], ens[p]);
      for (int i = 0; i < 255; i++) add_random(ins[p], outs[p]);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (pending.size() > 0 || s_tvalid || cfg_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
